FILE: rtl/tail_conditional_mean_macros.svh
// Assertion macros shared by the tail conditional mean RTL.
// No dependencies; included inside module bodies.
`ifndef TAIL_CONDITIONAL_MEAN_MACROS_SVH
`define TAIL_CONDITIONAL_MEAN_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define TCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcm: same-cycle check failed");

// Next-cycle implication under synchronous active-low reset.
`define TCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcm: next-cycle check failed");

`endif

FILE: rtl/tcm_pkg.sv
// Shared types and constants for the tail conditional mean block.
// No dependencies.
package tcm_pkg;
    localparam int DIST_IN_W     = 32;
    localparam int MEAN_W        = 40;
    localparam int COUNT_W       = 11;
    localparam int GAMMA_W       = 16;
    localparam int OPEN_W        = 10;
    localparam int FRAC_W        = 8;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int Q_DEPTH       = 4;
    localparam int MAX_ITEMS_DEF = 1024;
    localparam int DIST_BITS_DEF = 32;

    localparam logic REG_GAMMA = 1'b0;
    localparam logic REG_OPEN  = 1'b1;

    typedef struct packed {
        logic eval;
        logic last;
    } t_item_ctl;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_KMUL,
        ST_KSET,
        ST_SCAN,
        ST_SUM,
        ST_TMUL,
        ST_TADD,
        ST_DIV,
        ST_OUT
    } t_back_state;
endpackage

FILE: rtl/tcm_if.sv
// Valid/ready channel interfaces for node items and tail results.
// Depends on tcm_pkg.
interface tcm_in_if;
    import tcm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [DIST_IN_W-1:0] closest_dist;
    logic [DIST_IN_W-1:0] new_dist;
    logic                 func;
    logic                 last;
    modport source (output valid, closest_dist, new_dist, func, last, input ready);
    modport sink   (input valid, closest_dist, new_dist, func, last, output ready);
endinterface

interface tcm_out_if;
    import tcm_pkg::*;
    logic               valid;
    logic               ready;
    logic [MEAN_W-1:0]  tail_mean;
    logic [COUNT_W-1:0] tail_count;
    logic               none_open;
    modport source (output valid, tail_mean, tail_count, none_open, input ready);
    modport sink   (input valid, tail_mean, tail_count, none_open, output ready);
endinterface

FILE: rtl/tcm_front.sv
// Front stage: accepts node items, forms the impact and tags the item.
// Depends on tcm_pkg.
module tcm_front #(
    parameter int DIST_BITS = tcm_pkg::DIST_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tcm_pkg::DIST_IN_W-1:0] i_closest_dist,
    input  logic [tcm_pkg::DIST_IN_W-1:0] i_new_dist,
    input  logic                          i_func,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [DIST_BITS-1:0]          o_impact,
    output tcm_pkg::t_item_ctl            o_ctl
);
    import tcm_pkg::*;

    logic                 r_valid;
    logic [DIST_BITS-1:0] r_impact;
    t_item_ctl            r_ctl;
    logic [DIST_BITS-1:0] w_cd;
    logic [DIST_BITS-1:0] w_nd;
    logic [DIST_BITS-1:0] w_imp;

    generate
        if (DIST_BITS >= DIST_IN_W) begin : g_wide
            assign w_cd = DIST_BITS'(i_closest_dist);
            assign w_nd = DIST_BITS'(i_new_dist);
        end else begin : g_sat
            assign w_cd = (|i_closest_dist[DIST_IN_W-1:DIST_BITS]) ? '1
                          : i_closest_dist[DIST_BITS-1:0];
            assign w_nd = (|i_new_dist[DIST_IN_W-1:DIST_BITS]) ? '1
                          : i_new_dist[DIST_BITS-1:0];
        end
    endgenerate

    assign w_imp   = (i_func && (w_nd < w_cd)) ? w_nd : w_cd;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_impact = r_impact;
    assign o_ctl   = r_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_impact  <= w_imp;
            r_ctl.eval <= i_func;
            r_ctl.last <= i_last;
        end
    end
endmodule

FILE: rtl/tcm_queue.sv
// Short queue between front and back stages.
// Depends on tcm_pkg.
module tcm_queue #(
    parameter int DIST_BITS = tcm_pkg::DIST_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [DIST_BITS-1:0] i_impact,
    input  tcm_pkg::t_item_ctl   i_ctl,
    output logic                 o_valid,
    input  logic                 i_pop,
    output logic [DIST_BITS-1:0] o_impact,
    output tcm_pkg::t_item_ctl   o_ctl
);
    import tcm_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int LVL_W = $clog2(Q_DEPTH + 1);

    logic [DIST_BITS-1:0] r_impact [Q_DEPTH];
    t_item_ctl            r_ctl [Q_DEPTH];
    logic [PTR_W-1:0]     r_wr;
    logic [PTR_W-1:0]     r_rd;
    logic [LVL_W-1:0]     r_level;
    logic                 w_push;
    logic                 w_pop;

    assign o_ready  = (r_level != LVL_W'(Q_DEPTH));
    assign o_valid  = (r_level != '0);
    assign w_push   = i_valid && o_ready;
    assign w_pop    = i_pop && o_valid;
    assign o_impact = r_impact[r_rd];
    assign o_ctl    = r_ctl[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_level <= r_level + LVL_W'(1);
            end else if (w_pop && !w_push) begin
                r_level <= r_level - LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_impact[r_wr] <= i_impact;
            r_ctl[r_wr]    <= i_ctl;
        end
    end
endmodule

FILE: rtl/tcm_back.sv
// Back stage: stores impacts, selects the k largest by radix search,
// sums and divides them, and holds the result. Depends on tcm_pkg and macros.
module tcm_back #(
    parameter int MAX_ITEMS = tcm_pkg::MAX_ITEMS_DEF,
    parameter int DIST_BITS = tcm_pkg::DIST_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  logic [DIST_BITS-1:0]        i_q_impact,
    input  tcm_pkg::t_item_ctl          i_q_ctl,
    input  logic [tcm_pkg::GAMMA_W-1:0] i_gamma,
    input  logic [tcm_pkg::OPEN_W-1:0]  i_open,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [tcm_pkg::MEAN_W-1:0]  o_tail_mean,
    output logic [tcm_pkg::COUNT_W-1:0] o_tail_count,
    output logic                        o_none_open
);
    import tcm_pkg::*;
    `include "tail_conditional_mean_macros.svh"

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int BIT_W  = (DIST_BITS > 1) ? $clog2(DIST_BITS) : 1;
    localparam int SUM_W  = DIST_BITS + CNT_W;
    localparam int DIV_W  = SUM_W + FRAC_W;
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam int KP_W   = CNT_W + GAMMA_W + 1;
    localparam int CL_W   = KP_W + 1 - GAMMA_W;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [DIST_BITS-1:0] r_mem [MAX_ITEMS];
    logic [CNT_W-1:0]     r_count;
    logic                 r_eval;
    logic [KP_W-1:0]      r_kprod;
    logic [CNT_W-1:0]     r_k;
    logic [CNT_W-1:0]     r_addr;
    logic                 r_rd_vld;
    logic [DIST_BITS-1:0] r_rd_data;
    logic [BIT_W-1:0]     r_bit;
    logic [DIST_BITS-1:0] r_prefix;
    logic [DIST_BITS-1:0] r_mask;
    logic [CNT_W-1:0]     r_hits;
    logic [CNT_W-1:0]     r_greater;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     r_prod;
    logic [DIV_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [STEP_W-1:0]    r_step;
    logic                 r_out_valid;
    logic [MEAN_W-1:0]    r_out_mean;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_none;

    logic                 w_pop;
    logic                 w_we;
    logic                 w_issue;
    logic                 w_done;
    logic                 w_out_load;
    logic [DIST_BITS-1:0] w_bit_oh;
    logic [CNT_W:0]       w_total;
    logic [CL_W-1:0]      w_ceil;
    logic [KP_W:0]        w_ceil_sum;
    logic [CL_W-1:0]      w_n;
    logic [CL_W-1:0]      w_kraw;
    logic [CNT_W-1:0]     w_k;
    logic [CNT_W:0]       w_rem_sh;
    logic                 w_ge;
    logic [MEAN_W-1:0]    w_mean;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_q_valid && i_q_ctl.last) begin
                    n_state = ST_KMUL;
                end
            end
            ST_KMUL: n_state = ST_KSET;
            ST_KSET: n_state = ST_SCAN;
            ST_SCAN: begin
                if (w_done && (r_bit == '0)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (w_done) begin
                    n_state = ST_TMUL;
                end
            end
            ST_TMUL: n_state = ST_TADD;
            ST_TADD: n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == STEP_W'(1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        w_pop      = (r_state == ST_LOAD);
        w_we       = w_pop && i_q_valid && (r_count < CNT_W'(MAX_ITEMS));
        w_issue    = ((r_state == ST_SCAN) || (r_state == ST_SUM)) && (r_addr < r_count);
        w_done     = ((r_state == ST_SCAN) || (r_state == ST_SUM)) && (r_addr == r_count)
                     && !r_rd_vld;
        w_out_load = (r_state == ST_OUT) && (!r_out_valid || i_res_ready);
    end

    assign o_q_pop = w_pop;

    assign w_bit_oh   = DIST_BITS'(1) << r_bit;
    assign w_total    = {1'b0, r_greater} + {1'b0, r_hits};
    assign w_ceil_sum = {1'b0, r_kprod} + (KP_W + 1)'((1 << GAMMA_W) - 1);
    assign w_ceil     = w_ceil_sum[KP_W:GAMMA_W];
    assign w_n        = CL_W'(r_count);

    always_comb begin
        if (w_ceil > w_n) begin
            w_kraw = CL_W'(1);
        end else begin
            w_kraw = w_n - w_ceil + CL_W'(1);
        end
        if (w_kraw > w_n) begin
            w_kraw = w_n;
        end
        if (w_kraw == '0) begin
            w_kraw = CL_W'(1);
        end
        w_k = w_kraw[CNT_W-1:0];
    end

    assign w_rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_k});

    generate
        if (DIV_W > MEAN_W) begin : g_sat
            assign w_mean = (|r_quo[DIV_W-1:MEAN_W]) ? '1 : r_quo[MEAN_W-1:0];
        end else begin : g_fit
            assign w_mean = MEAN_W'(r_quo);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (w_we) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_out_load) begin
                r_count <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_q_impact;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_addr <= r_addr + CNT_W'(1);
        end
        unique case (r_state)
            ST_LOAD: begin
                if (i_q_valid && i_q_ctl.last) begin
                    r_eval <= i_q_ctl.eval;
                end
            end
            ST_KMUL: begin
                r_kprod <= KP_W'(r_count) * (KP_W'(1 << GAMMA_W) - KP_W'(i_gamma));
            end
            ST_KSET: begin
                r_k       <= w_k;
                r_bit     <= BIT_W'(DIST_BITS - 1);
                r_prefix  <= '0;
                r_mask    <= '0;
                r_hits    <= '0;
                r_greater <= '0;
                r_addr    <= '0;
                r_sum     <= '0;
            end
            ST_SCAN: begin
                if (r_rd_vld && (((r_rd_data ^ r_prefix) & r_mask) == '0)
                    && r_rd_data[r_bit]) begin
                    r_hits <= r_hits + CNT_W'(1);
                end
                if (w_done) begin
                    if (w_total >= {1'b0, r_k}) begin
                        r_prefix <= r_prefix | w_bit_oh;
                    end else begin
                        r_greater <= w_total[CNT_W-1:0];
                    end
                    r_mask <= r_mask | w_bit_oh;
                    r_hits <= '0;
                    r_addr <= '0;
                    if (r_bit != '0) begin
                        r_bit <= r_bit - BIT_W'(1);
                    end
                end
            end
            ST_SUM: begin
                if (r_rd_vld && (r_rd_data > r_prefix)) begin
                    r_sum <= r_sum + SUM_W'(r_rd_data);
                end
            end
            ST_TMUL: begin
                r_prod <= SUM_W'(r_k - r_greater) * SUM_W'(r_prefix);
            end
            ST_TADD: begin
                r_quo  <= {r_sum + r_prod, FRAC_W'(0)};
                r_rem  <= '0;
                r_step <= STEP_W'(DIV_W);
            end
            ST_DIV: begin
                r_rem  <= w_ge ? CNT_W'(w_rem_sh - {1'b0, r_k}) : w_rem_sh[CNT_W-1:0];
                r_quo  <= {r_quo[DIV_W-2:0], w_ge};
                r_step <= r_step - STEP_W'(1);
            end
            ST_OUT: begin
                if (w_out_load) begin
                    r_out_none  <= !r_eval && (i_open == '0);
                    r_out_mean  <= (!r_eval && (i_open == '0)) ? '1 : w_mean;
                    r_out_count <= COUNT_W'(r_k);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid  = r_out_valid;
    assign o_tail_mean  = r_out_mean;
    assign o_tail_count = r_out_count;
    assign o_none_open  = r_out_none;

    `TCM_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_ITEMS))
    `TCM_ASSERT_NOW(a_k_range, i_clk, i_rst_n, r_state == ST_DIV, (r_k != '0) && (r_k <= r_count))
    `TCM_ASSERT_NOW(a_rem_lt_k, i_clk, i_rst_n, r_state == ST_DIV, r_rem < r_k)
    `TCM_ASSERT_NEXT(a_count_clear, i_clk, i_rst_n, w_out_load, r_count == '0)
endmodule

FILE: rtl/tail_conditional_mean.sv
// Top level of the tail conditional mean block: APB registers, front, queue, back.
// Depends on tcm_pkg, tcm_if, tcm_front, tcm_queue, tcm_back.
//
//   channel  dir  handshake         payload
//   i_in     in   valid/ready       closest_dist, new_dist, func, last
//   o_out    out  valid/ready       tail_mean, tail_count, none_open
//   apb      in   psel/penable      paddr, pwdata, pwrite, prdata (pready high)
//
// Items load at one per cycle and the store takes one impact per cycle while the back stage loads a set.
// After the last item of a set the back stage forms k, makes one radix pass over the
// impact memory per distance bit, sums the k largest impacts and divides by k over
// DIV_W = DIST_BITS + clog2(MAX_ITEMS+1) + 8 quotient bits.
// Synchronous active-low reset; the impact memory needs no clearing.
// One finished result waits in the output register while the next set loads; a further result holds ST_OUT.
module tail_conditional_mean #(
    parameter int MAX_ITEMS = tcm_pkg::MAX_ITEMS_DEF,
    parameter int DIST_BITS = tcm_pkg::DIST_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tcm_in_if.sink                         i_in,
    tcm_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tcm_pkg::*;

    logic [GAMMA_W-1:0]   r_gamma;
    logic [OPEN_W-1:0]    r_open;
    logic                 w_wr;
    logic                 w_f_valid;
    logic                 w_f_ready;
    logic [DIST_BITS-1:0] w_f_impact;
    t_item_ctl            w_f_ctl;
    logic                 w_q_valid;
    logic                 w_q_pop;
    logic [DIST_BITS-1:0] w_q_impact;
    t_item_ctl            w_q_ctl;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_OPEN) ? APB_DATA_W'(r_open) : APB_DATA_W'(r_gamma);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= '0;
            r_open  <= '0;
        end else if (w_wr) begin
            if (paddr[2] == REG_GAMMA) begin
                r_gamma <= pwdata[GAMMA_W-1:0];
            end else begin
                r_open <= pwdata[OPEN_W-1:0];
            end
        end
    end

    tcm_front #(.DIST_BITS(DIST_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_closest_dist (i_in.closest_dist),
        .i_new_dist     (i_in.new_dist),
        .i_func         (i_in.func),
        .i_last         (i_in.last),
        .o_valid        (w_f_valid),
        .i_ready        (w_f_ready),
        .o_impact       (w_f_impact),
        .o_ctl          (w_f_ctl)
    );

    tcm_queue #(.DIST_BITS(DIST_BITS)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_f_valid),
        .o_ready  (w_f_ready),
        .i_impact (w_f_impact),
        .i_ctl    (w_f_ctl),
        .o_valid  (w_q_valid),
        .i_pop    (w_q_pop),
        .o_impact (w_q_impact),
        .o_ctl    (w_q_ctl)
    );

    tcm_back #(.MAX_ITEMS(MAX_ITEMS), .DIST_BITS(DIST_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_q_pop      (w_q_pop),
        .i_q_impact   (w_q_impact),
        .i_q_ctl      (w_q_ctl),
        .i_gamma      (r_gamma),
        .i_open       (r_open),
        .o_res_valid  (o_out.valid),
        .i_res_ready  (o_out.ready),
        .o_tail_mean  (o_out.tail_mean),
        .o_tail_count (o_out.tail_count),
        .o_none_open  (o_out.none_open)
    );
endmodule

FILE: dv/tcm_checker.sv
// Checker for the tail conditional mean block: watches the item, result and register ports.
// Predicts each result from its own copy of the impacts and registers and compares.
// Depends on tcm_pkg and tcm_if.
`timescale 1ns / 1ps
module tcm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tcm_in_if                              in_ch,
    tcm_out_if                             out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [tcm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcm_pkg::APB_DATA_W-1:0] pwdata,
    output int                             o_errors,
    output int                             o_pending
);
    import tcm_pkg::*;

    localparam int          DEPTH     = MAX_ITEMS_DEF;
    localparam logic [63:0] MEAN_FULL = (64'd1 << MEAN_W) - 1;

    typedef struct packed {
        logic [MEAN_W-1:0]  tail_mean;
        logic [COUNT_W-1:0] tail_count;
        logic               none_open;
    } t_tail_result;

    t_tail_result        tail_q[$];
    logic [31:0]         ranked[DEPTH];
    int                  held;
    logic [GAMMA_W-1:0]  gamma_reg;
    logic [OPEN_W-1:0]   open_reg;

    logic [31:0]  impact;
    logic [63:0]  ceil_part;
    logic [63:0]  kval;
    logic [63:0]  sum;
    logic [63:0]  quo;
    logic [63:0]  rem;
    logic [63:0]  mean;
    int           pos;
    t_tail_result want;
    t_tail_result got;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held      = 0;
            gamma_reg = '0;
            open_reg  = '0;
            tail_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_OPEN) open_reg = pwdata[OPEN_W-1:0];
                else gamma_reg = pwdata[GAMMA_W-1:0];
            end
            if (in_ch.valid && in_ch.ready) begin
                impact = (in_ch.func && in_ch.new_dist < in_ch.closest_dist) ?
                         in_ch.new_dist : in_ch.closest_dist;
                if (held < DEPTH) begin
                    pos = held;
                    while (pos > 0 && ranked[pos-1] < impact) begin
                        ranked[pos] = ranked[pos-1];
                        pos--;
                    end
                    ranked[pos] = impact;
                    held++;
                end
                if (in_ch.last) begin
                    ceil_part = (64'(held) * (64'd65536 - 64'(gamma_reg)) + 64'd65535) >> 16;
                    kval = (ceil_part > 64'(held)) ? 64'd1 : 64'(held) - ceil_part + 64'd1;
                    if (kval > 64'(held)) kval = 64'(held);
                    if (kval < 64'd1) kval = 64'd1;
                    sum = 0;
                    for (int j = 0; j < kval; j++) sum += 64'(ranked[j]);
                    quo = sum / kval;
                    rem = sum % kval;
                    if (quo > (MEAN_FULL >> FRAC_W)) mean = MEAN_FULL;
                    else mean = (quo << FRAC_W) + (rem << FRAC_W) / kval;
                    if (mean > MEAN_FULL) mean = MEAN_FULL;
                    want.tail_count = kval[COUNT_W-1:0];
                    if (!in_ch.func && open_reg == 0) begin
                        want.tail_mean = MEAN_FULL[MEAN_W-1:0];
                        want.none_open = 1'b1;
                    end else begin
                        want.tail_mean = mean[MEAN_W-1:0];
                        want.none_open = 1'b0;
                    end
                    tail_q.push_back(want);
                    held = 0;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                got.tail_mean  = out_ch.tail_mean;
                got.tail_count = out_ch.tail_count;
                got.none_open  = out_ch.none_open;
                if (tail_q.size() == 0) begin
                    $error("unexpected result: tail_mean %h tail_count %0d none_open %0b",
                           got.tail_mean, got.tail_count, got.none_open);
                    o_errors <= o_errors + 1;
                end else begin
                    want = tail_q.pop_front();
                    if (got != want) o_errors <= o_errors + 1;
                    if (got.tail_mean !== want.tail_mean)
                        $error("tail_mean: expected %h actual %h", want.tail_mean, got.tail_mean);
                    if (got.tail_count !== want.tail_count)
                        $error("tail_count: expected %0d actual %0d",
                               want.tail_count, got.tail_count);
                    if (got.none_open !== want.none_open)
                        $error("none_open: expected %0b actual %0b",
                               want.none_open, got.none_open);
                end
            end
            o_pending <= tail_q.size();
        end
    end
endmodule

FILE: dv/tb.sv
// Testbench top for the tail conditional mean block: clock, reset, register writes,
// node items and result back-pressure; verdict from the checker's failure count.
// Depends on tcm_pkg, tcm_if, tail_conditional_mean and tcm_checker.
`timescale 1ns / 1ps
module tb;
    import tcm_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;
    bit                    calm;
    int                    hold_req;
    int                    hold_left;
    int                    sent;

    tcm_in_if  in_if ();
    tcm_out_if out_if ();

    tail_conditional_mean uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    tcm_checker chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .in_ch    (in_if),
        .out_ch   (out_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .o_errors (fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        out_if.ready = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
            end
        end
    end

    task automatic reg_write(input logic reg_sel, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(input logic [31:0] cd, input logic [31:0] nd,
                             input logic fn, input logic lst);
        if (!calm && $urandom_range(99) < 18) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        in_if.valid        <= 1'b1;
        in_if.closest_dist <= cd;
        in_if.new_dist     <= nd;
        in_if.func         <= fn;
        in_if.last         <= lst;
        @(negedge i_clk);
        while (!in_if.ready) @(negedge i_clk);
        @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_dist();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(255));
            3: return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int size, input logic fn_last);
        for (int j = 0; j < size; j++)
            send_item(pick_dist(), pick_dist(),
                      (j == size - 1) ? fn_last : 1'($urandom), j == size - 1);
    endtask

    initial begin
        int size;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.closest_dist = '0;
        in_if.new_dist     = '0;
        in_if.func         = 1'b0;
        in_if.last         = 1'b0;
        calm               = 1'b0;
        hold_req           = 0;
        sent               = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_write(REG_GAMMA, 32'd0);
        reg_write(REG_OPEN, 32'd0);
        send_item(32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_item(32'hFFFF_FFFF, 32'd5, 1'b1, 1'b1);
        send_item(32'd9, 32'd7, 1'b1, 1'b0);
        send_item(32'd3, 32'd7, 1'b1, 1'b1);
        drain();
        reg_write(REG_GAMMA, 32'hFFFF);
        reg_write(REG_OPEN, 32'd1023);
        send_item(32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        send_item(32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        send_item(32'h0, 32'h0, 1'b0, 1'b1);
        send_item(32'd42, 32'd42, 1'b1, 1'b0);
        send_item(32'd42, 32'd42, 1'b0, 1'b1);
        drain();
        reg_write(REG_GAMMA, 32'h8000);
        reg_write(REG_OPEN, 32'd1);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 1'b0);
        send_item(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0);
        send_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0);
        send_item(32'h1, 32'h0, 1'b1, 1'b0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: reg_write(REG_GAMMA, 32'd0);
                1: reg_write(REG_GAMMA, 32'hFFFF);
                2: reg_write(REG_GAMMA, 32'h8000);
                3: reg_write(REG_GAMMA, 32'd1);
                default: reg_write(REG_GAMMA, 32'($urandom_range(65535)));
            endcase
            if (p % 3 == 0) reg_write(REG_OPEN, 32'd0);
            else if (p == 1) reg_write(REG_OPEN, 32'd1023);
            else reg_write(REG_OPEN, 32'($urandom_range(1023)));
            calm = (p == 0);
            if (p == 2) begin
                @(negedge i_clk);
                hold_req = 4000;
                for (int s = 0; s < 10; s++) send_set($urandom_range(1, 2), 1'($urandom));
            end
            sent = 0;
            while (sent < 60) begin
                size = ($urandom_range(9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
                send_set(size, 1'($urandom));
            end
            drain();
        end

        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
